// ===== rtl/mpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared types, constants and arithmetic helpers of the max product path
// grid block.
// ----------------------------------------------------------------------------
package mpp_pkg;

	localparam int MAX_COLUMNS_DEF = 16;
	localparam int COLUMNS_W       = 5;
	localparam logic [COLUMNS_W-1:0] COLUMNS_RESET = 5'd16;

	localparam int VALUE_W  = 4;
	localparam int ANSWER_W = 31;
	localparam int PROD_W   = 64;
	localparam int MUL_W    = PROD_W + VALUE_W;
	localparam int MAG_W    = PROD_W - 1;

	localparam logic [31:0] MODULUS   = 32'd1000000007;
	localparam logic [31:0] MODULUS_2 = 32'd2000000014;
	localparam logic [31:0] MODULUS_3 = 32'd3000000021;
	localparam logic [ANSWER_W-1:0] ANSWER_NEG = 31'h7FFF_FFFF;

	// remainder pipeline: top bits start below the modulus, then 2 bits a stage
	localparam int MOD_REM_W    = 30;
	localparam int MOD_TOP_BITS = 29;
	localparam int MOD_DIGIT_W  = 2;
	localparam int MOD_REST_W   = MAG_W - MOD_TOP_BITS;
	localparam int MOD_STEPS    = MOD_REST_W / MOD_DIGIT_W;

	localparam int OUT_DEPTH = 32;
	localparam int OUT_PTR_W = 5;
	localparam int OUT_CNT_W = 6;

	typedef logic signed [VALUE_W-1:0]  cell_val_t;
	typedef logic signed [ANSWER_W-1:0] answer_t;
	typedef logic signed [PROD_W-1:0]   prod_t;

	typedef struct packed {
		prod_t hi;
		prod_t lo;
	} ext_t;

	typedef struct packed {
		logic             valid;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} best_t;

	localparam prod_t PROD_MAX = {1'b0, {(PROD_W-1){1'b1}}};
	localparam prod_t PROD_MIN = {1'b1, {(PROD_W-1){1'b0}}};

	function automatic prod_t sat_mul(prod_t a, cell_val_t b);
		logic signed [MUL_W-1:0] p;
		p = MUL_W'(a) * MUL_W'(b);
		if (p[MUL_W-1:PROD_W-1] == {(MUL_W-PROD_W+1){p[MUL_W-1]}}) begin
			return p[PROD_W-1:0];
		end else if (p[MUL_W-1]) begin
			return PROD_MIN;
		end else begin
			return PROD_MAX;
		end
	endfunction

	function automatic logic [MOD_REM_W-1:0] mod_step(logic [MOD_REM_W-1:0] rem,
			logic [MOD_DIGIT_W-1:0] digit);
		logic [31:0] t;
		logic [31:0] r;
		t = {rem, digit};
		priority if (t >= MODULUS_3) begin
			r = t - MODULUS_3;
		end else if (t >= MODULUS_2) begin
			r = t - MODULUS_2;
		end else if (t >= MODULUS) begin
			r = t - MODULUS;
		end else begin
			r = t;
		end
		return r[MOD_REM_W-1:0];
	endfunction

endpackage

// ===== rtl/mpp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_if
// Handshake channels of the max product path grid block: cells in,
// answers out, column count configuration.
// ----------------------------------------------------------------------------
interface mpp_cell_if;
	logic              valid;
	logic              ready;
	mpp_pkg::cell_val_t cell_value;
	logic              last_cell;

	modport source(output valid, cell_value, last_cell, input ready);
	modport sink(input valid, cell_value, last_cell, output ready);
endinterface

interface mpp_answer_if;
	logic            valid;
	logic            ready;
	mpp_pkg::answer_t answer;

	modport source(output valid, answer, input ready);
	modport sink(input valid, answer, output ready);
endinterface

interface mpp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mpp_pkg::COLUMNS_W-1:0]   columns;

	modport source(output valid, columns, input ready);
	modport sink(input valid, columns, output ready);
endinterface

// ===== rtl/max_product_path_grid_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_product_path_grid_dp
// Maximum path product over a grid, right and down moves, cells streamed
// in row-major order; answer mod 1000000007 or -1 on the last cell.
// ----------------------------------------------------------------------------
// Takes one cell per clock. Each cell does one read of the column store
// (16 x 128 bits, max and min product, one read and one write port) and
// uses the previous cell held in a register as its left neighbor; a cell
// whose column equals the previous cell's (single-column grids) takes the
// top value from that register as well. The answer of a last cell passes
// through the update register, 18 remainder stages and an answer queue
// of 32 entries before it leaves the result channel. The cell input
// stalls only while 32 answers are outstanding.
// ----------------------------------------------------------------------------
module max_product_path_grid_dp #(
	parameter int MAX_COLUMNS = mpp_pkg::MAX_COLUMNS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mpp_cfg_if.sink       cfg,
	mpp_cell_if.sink      cells,
	mpp_answer_if.source  result
);

	localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CW    = mpp_pkg::COLUMNS_W;
	localparam logic [CW-1:0] MAX_COLS_CFG = CW'(MAX_COLUMNS);

	logic [CW-1:0]                 columns_q;
	logic [COL_W-1:0]              col_idx_q;
	logic [COL_W-1:0]              prev_col_q;
	logic                          first_row_q;
	logic [mpp_pkg::OUT_CNT_W-1:0] pending_q;

	logic                 valid_s1;
	mpp_pkg::cell_val_t   val_s1;
	logic                 last_s1;
	logic [COL_W-1:0]     col_s1;
	logic                 use_top_s1;
	logic                 use_left_s1;
	logic                 fwd_s1;

	mpp_pkg::ext_t        left_q;
	mpp_pkg::ext_t        top_rd;
	mpp_pkg::ext_t        top;
	mpp_pkg::ext_t        upd;
	mpp_pkg::prod_t       cmax;
	mpp_pkg::prod_t       cmin;
	mpp_pkg::prod_t       pa;
	mpp_pkg::prod_t       pb;
	mpp_pkg::best_t       best;

	logic [CW-1:0] eff_cols;
	logic          row_end;
	logic          acc;
	logic          res_acc;
	logic          ans_valid;
	mpp_pkg::answer_t ans;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= mpp_pkg::COLUMNS_RESET;
		end else if (cfg.valid) begin
			columns_q <= cfg.columns;
		end
	end

	always_comb begin
		priority if (columns_q == '0) begin
			eff_cols = CW'(1);
		end else if (columns_q > MAX_COLS_CFG) begin
			eff_cols = MAX_COLS_CFG;
		end else begin
			eff_cols = columns_q;
		end
	end

	assign row_end = ((CW+1)'(col_idx_q) + (CW+1)'(1)) >= (CW+1)'(eff_cols);

	// cell sequencing
	assign cells.ready = (pending_q < mpp_pkg::OUT_CNT_W'(mpp_pkg::OUT_DEPTH));
	assign acc         = cells.valid && cells.ready;
	assign res_acc     = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_idx_q   <= '0;
			prev_col_q  <= '0;
			first_row_q <= 1'b1;
			valid_s1    <= 1'b0;
			pending_q   <= '0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				prev_col_q <= col_idx_q;
				if (cells.last_cell) begin
					col_idx_q   <= '0;
					first_row_q <= 1'b1;
				end else if (row_end) begin
					col_idx_q   <= '0;
					first_row_q <= 1'b0;
				end else begin
					col_idx_q <= col_idx_q + 1'b1;
				end
			end
			unique case ({acc && cells.last_cell, res_acc})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			val_s1      <= cells.cell_value;
			last_s1     <= cells.last_cell;
			col_s1      <= col_idx_q;
			use_top_s1  <= !first_row_q;
			use_left_s1 <= (col_idx_q != '0);
			fwd_s1      <= (col_idx_q == prev_col_q);
		end
		if (valid_s1) begin
			left_q <= upd;
		end
	end

	mpp_col_store #(
		.DEPTH  (MAX_COLUMNS),
		.ADDR_W (COL_W)
	) u_store (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (col_idx_q),
		.rd_data (top_rd),
		.wr_en   (valid_s1),
		.wr_addr (col_s1),
		.wr_data (upd)
	);

	// update: extremes of the candidates, both scaled by the cell value
	always_comb begin
		top = fwd_s1 ? left_q : top_rd;
		priority if (use_top_s1 && use_left_s1) begin
			cmax = ($signed(top.hi) > $signed(left_q.hi)) ? top.hi : left_q.hi;
			cmin = ($signed(top.lo) < $signed(left_q.lo)) ? top.lo : left_q.lo;
		end else if (use_top_s1) begin
			cmax = top.hi;
			cmin = top.lo;
		end else begin
			cmax = left_q.hi;
			cmin = left_q.lo;
		end
		pa = mpp_pkg::sat_mul(cmax, val_s1);
		pb = mpp_pkg::sat_mul(cmin, val_s1);
		priority if (!use_top_s1 && !use_left_s1) begin
			upd.hi = mpp_pkg::PROD_W'(val_s1);
			upd.lo = mpp_pkg::PROD_W'(val_s1);
		end else if (!val_s1[mpp_pkg::VALUE_W-1]) begin
			upd.hi = pa;
			upd.lo = pb;
		end else begin
			upd.hi = pb;
			upd.lo = pa;
		end
	end

	always_comb begin
		best.valid = valid_s1 && last_s1;
		best.neg   = upd.hi[mpp_pkg::PROD_W-1];
		best.mag   = upd.hi[mpp_pkg::MAG_W-1:0];
	end

	mpp_mod_pipe u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.best_in   (best),
		.ans_valid (ans_valid),
		.ans       (ans)
	);

	mpp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ans_valid),
		.push_data (ans),
		.pop       (res_acc),
		.valid     (result.valid),
		.data      (result.answer)
	);

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= mpp_pkg::OUT_CNT_W'(mpp_pkg::OUT_DEPTH))
		else $error("outstanding answer count out of range");

	a_grid_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cells.last_cell |=> first_row_q && (col_idx_q == '0))
		else $error("grid did not restart after last cell");

	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (pending_q != '0))
		else $error("answer presented with none outstanding");

endmodule

// ===== rtl/mpp_col_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_col_store
// Per-column path extremes (max and min product), one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module mpp_col_store #(
	parameter int DEPTH  = mpp_pkg::MAX_COLUMNS_DEF,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output mpp_pkg::ext_t     rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  mpp_pkg::ext_t     wr_data
);

	mpp_pkg::ext_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/mpp_mod_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_mod_pipe
// Pipelined remainder by 1000000007: two magnitude bits folded in per
// stage with one compare-subtract. Negative best products map to -1.
// ----------------------------------------------------------------------------
module mpp_mod_pipe (
	input  logic             clk,
	input  logic             arst_n,
	input  mpp_pkg::best_t   best_in,
	output logic             ans_valid,
	output mpp_pkg::answer_t ans
);

	localparam int STEPS = mpp_pkg::MOD_STEPS;
	localparam int REM_W = mpp_pkg::MOD_REM_W;
	localparam int REST_W = mpp_pkg::MOD_REST_W;
	localparam int DIG_W = mpp_pkg::MOD_DIGIT_W;

	logic              valid_q [STEPS+1];
	logic              neg_q   [STEPS+1];
	logic [REM_W-1:0]  rem_q   [STEPS+1];
	logic [REST_W-1:0] rest_q  [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) begin
				valid_q[k] <= 1'b0;
			end
		end else begin
			valid_q[0] <= best_in.valid;
			for (int k = 1; k <= STEPS; k++) begin
				valid_q[k] <= valid_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		neg_q[0]  <= best_in.neg;
		rem_q[0]  <= REM_W'(best_in.mag[mpp_pkg::MAG_W-1:REST_W]);
		rest_q[0] <= best_in.mag[REST_W-1:0];
		for (int k = 1; k <= STEPS; k++) begin
			neg_q[k]  <= neg_q[k-1];
			rem_q[k]  <= mpp_pkg::mod_step(rem_q[k-1], rest_q[k-1][REST_W-1 -: DIG_W]);
			rest_q[k] <= {rest_q[k-1][REST_W-DIG_W-1:0], {DIG_W{1'b0}}};
		end
	end

	assign ans_valid = valid_q[STEPS];
	assign ans = neg_q[STEPS] ? mpp_pkg::ANSWER_NEG : {1'b0, rem_q[STEPS]};

endmodule

// ===== rtl/mpp_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_out_fifo
// Answer queue between the remainder pipeline and the result channel.
// Room is reserved upstream when a last cell is taken.
// ----------------------------------------------------------------------------
module mpp_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mpp_pkg::answer_t push_data,
	input  logic             pop,
	output logic             valid,
	output mpp_pkg::answer_t data
);

	localparam int DEPTH = mpp_pkg::OUT_DEPTH;

	mpp_pkg::answer_t                  mem_q [DEPTH];
	logic [mpp_pkg::OUT_PTR_W-1:0]     wr_ptr_q;
	logic [mpp_pkg::OUT_PTR_W-1:0]     rd_ptr_q;
	logic [mpp_pkg::OUT_CNT_W-1:0]     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign valid = (count_q != '0);
	assign data  = mem_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < mpp_pkg::OUT_CNT_W'(DEPTH)) || pop)
		else $error("answer queue overflow");

endmodule
